### src/swd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD host package
// Shared types and constants of the SWD host transfer engine.
// ----------------------------------------------------------------------------
package swd_pkg;

    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned WORD_W      = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_ON_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CLOCKS = 2'd2;

    // Input item kinds.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [2:0] ACK_OK    = 3'd1;
    localparam logic [2:0] ACK_WAIT  = 3'd2;
    localparam logic [2:0] ACK_FAULT = 3'd4;

    // Start, stop and park bits of the request packet.
    localparam logic [7:0] REQ_FRAME = 8'h81;

    typedef struct packed {
        logic [2:0] turnaround;
        logic       data_on_wait;
        logic [7:0] idle_clocks;
    } t_swd_cfg;

    typedef struct packed {
        logic              swdio_out;
        logic              swdio_drive;
        logic              busy;
        logic              done;
        logic [2:0]        ack_code;
        logic              parity_error;
        logic [WORD_W-1:0] read_data;
    } t_swd_result;

endpackage

### src/swd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD configuration registers
// Write-only register file for turnaround, wait data phase and idle count.
// ----------------------------------------------------------------------------
module swd_cfg_regs
    import swd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_swd_cfg              o_cfg
);

    t_swd_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turnaround   <= 3'd1;
            r_cfg.data_on_wait <= 1'b0;
            r_cfg.idle_clocks  <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TURNAROUND:   r_cfg.turnaround   <= i_cfg_wdata[2:0];
                CFG_DATA_ON_WAIT: r_cfg.data_on_wait <= i_cfg_wdata[0];
                CFG_IDLE_CLOCKS:  r_cfg.idle_clocks  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/swd_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD bit engine
// Phase sequencer of one SWD transfer; one tick transaction is one SWCLK period.
// ----------------------------------------------------------------------------
module swd_bit_engine
    import swd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_swd_cfg          i_cfg,
    input  logic              i_accept,
    input  logic              i_command,
    input  logic [3:0]        i_req_nibble,
    input  logic [WORD_W-1:0] i_write_data,
    input  logic              i_swdio_in,
    output t_swd_result       o_result
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_REQ      = 4'd1,
        PH_TRN1     = 4'd2,
        PH_ACK      = 4'd3,
        PH_RDATA    = 4'd4,
        PH_TRN2     = 4'd5,
        PH_WDATA    = 4'd6,
        PH_IDLECYC  = 4'd7,
        PH_TAILIN   = 4'd8,
        PH_TAILZERO = 4'd9
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_cnt, n_cnt;
    logic [32:0] r_shift, n_shift;
    logic [7:0]  r_req, n_req;
    logic        r_rd, n_rd;
    logic [2:0]  r_ack, n_ack;
    logic        r_par, n_par;

    function automatic t_phase f_succ(t_phase p, logic [2:0] ack, logic rd, logic dpw);
        t_phase s;
        s = PH_IDLE;
        case (p)
            PH_REQ:   s = PH_TRN1;
            PH_TRN1:  s = PH_ACK;
            PH_ACK:   s = (ack == ACK_OK && rd) ? PH_RDATA : PH_TRN2;
            PH_RDATA: s = PH_TRN2;
            PH_TRN2: begin
                if (ack == ACK_OK) begin
                    s = rd ? PH_IDLECYC : PH_WDATA;
                end else if (ack == ACK_WAIT || ack == ACK_FAULT) begin
                    if (!dpw) s = PH_IDLE;
                    else      s = rd ? PH_TAILIN : PH_TAILZERO;
                end else begin
                    s = PH_TAILIN;
                end
            end
            PH_WDATA: s = PH_IDLECYC;
            default:  s = PH_IDLE;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] f_len(t_phase p, t_swd_cfg cfg);
        logic [7:0] n;
        n = 8'd0;
        case (p)
            PH_REQ:                                 n = 8'd8;
            PH_TRN1, PH_TRN2:                       n = {5'd0, cfg.turnaround};
            PH_ACK:                                 n = 8'd3;
            PH_RDATA, PH_WDATA, PH_TAILIN, PH_TAILZERO: n = 8'd33;
            PH_IDLECYC:                             n = cfg.idle_clocks;
            default:                                n = 8'd0;
        endcase
        return n;
    endfunction

    function automatic logic f_parity4(logic [3:0] v);
        return ^v;
    endfunction

    always_comb begin
        t_phase     p;
        logic [7:0] n;
        logic [7:0] dec;
        logic [1:0] ack_idx;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_req    = r_req;
        n_rd     = r_rd;
        n_ack    = r_ack;
        n_par    = r_par;
        p        = PH_IDLE;
        n        = 8'd0;
        dec      = 8'd0;
        ack_idx  = 2'(2'd3 - r_cnt[1:0]);
        o_result = '0;
        if (i_accept) begin
            if (i_command == CMD_START) begin
                // A start during a transfer leaves it untouched.
                if (r_phase == PH_IDLE) begin
                    n_rd    = i_req_nibble[1];
                    n_req   = REQ_FRAME | {2'b00, f_parity4(i_req_nibble),
                                           i_req_nibble, 1'b0};
                    n_shift = i_req_nibble[1] ? 33'd0 : {^i_write_data, i_write_data};
                    n_ack   = 3'd0;
                    n_par   = 1'b0;
                    n_phase = PH_REQ;
                    n_cnt   = 8'd8;
                end
            end else if (r_phase == PH_IDLE) begin
                o_result.swdio_out   = 1'b1;
                o_result.swdio_drive = 1'b1;
            end else begin
                case (r_phase)
                    PH_REQ: begin
                        o_result.swdio_drive = 1'b1;
                        o_result.swdio_out   = r_req[0];
                        n_req                = {1'b0, r_req[7:1]};
                    end
                    PH_ACK: begin
                        // ACK arrives LSB first while the count runs 3, 2, 1.
                        if (r_cnt >= 8'd1 && r_cnt <= 8'd3) begin
                            n_ack[ack_idx] = r_ack[ack_idx] | i_swdio_in;
                        end
                    end
                    PH_RDATA: begin
                        // After 33 shifts the first sampled bit sits in bit 0.
                        n_shift = {i_swdio_in, r_shift[32:1]};
                        n_par   = r_par ^ i_swdio_in;
                    end
                    PH_WDATA: begin
                        o_result.swdio_drive = 1'b1;
                        o_result.swdio_out   = r_shift[0];
                        n_shift              = {1'b0, r_shift[32:1]};
                    end
                    PH_IDLECYC, PH_TAILZERO: begin
                        o_result.swdio_drive = 1'b1;
                    end
                    default: ;
                endcase
                dec   = (r_cnt != 8'd0) ? r_cnt - 8'd1 : 8'd0;
                n_cnt = dec;
                if (dec == 8'd0) begin
                    // Phases of zero length are passed over in the same clock.
                    p = f_succ(r_phase, n_ack, r_rd, i_cfg.data_on_wait);
                    n = f_len(p, i_cfg);
                    for (int k = 0; k < 3; k++) begin
                        if (p != PH_IDLE && n == 8'd0) begin
                            p = f_succ(p, n_ack, r_rd, i_cfg.data_on_wait);
                            n = f_len(p, i_cfg);
                        end
                    end
                    n_phase = p;
                    n_cnt   = n;
                    if (p == PH_IDLE) begin
                        o_result.done = 1'b1;
                        if (n_ack == ACK_OK && r_rd) begin
                            o_result.parity_error = n_par;
                            o_result.read_data    = n_shift[WORD_W-1:0];
                        end
                    end
                end
            end
        end
        o_result.busy     = (n_phase != PH_IDLE);
        o_result.ack_code = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 8'd0;
            r_shift <= 33'd0;
            r_req   <= 8'd0;
            r_rd    <= 1'b0;
            r_ack   <= 3'd0;
            r_par   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_req   <= n_req;
            r_rd    <= n_rd;
            r_ack   <= n_ack;
            r_par   <= n_par;
        end
    end

    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_cnt != 8'd0)
        else $error("bit counter is zero inside an active phase");

    a_start_enters_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_command == CMD_START && r_phase == PH_IDLE)
        |=> (r_phase == PH_REQ && r_cnt == 8'd8))
        else $error("start did not enter the request phase");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.done |=> r_phase == PH_IDLE)
        else $error("transfer reported done but did not return to idle");

    a_ack_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_command == CMD_TICK && r_phase == PH_ACK) |-> !o_result.swdio_drive)
        else $error("host drives the line during the ACK phase");

endmodule

### src/swd_host_transfer_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD host transfer engine
// Bit-level SWD host: request, turnaround, ACK, data, idle and back-off.
// ----------------------------------------------------------------------------
// Each input transaction is either a start, which latches a request and a
// write word, or a tick, which stands for one SWCLK period and returns the
// level to drive, the drive enable and the transfer status. Every input
// transaction yields exactly one result transaction, in the next clock, held in
// a single output register. The block takes one input transaction per clock;
// the only thing that holds it back is a result left untaken in that output
// register, so throughput is one transaction per cycle while the sink keeps
// up. Configuration writes are meant to land while no transfer is running.
// ----------------------------------------------------------------------------
module swd_host_transfer_engine
    import swd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // request [3:0], write_data [35:4], swdio_in [36], zero [39:37]
    input  logic [39:0]           i_s_tdata,
    // command [0]
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // swdio_out [0], swdio_drive [1], busy_res [2], ack_code [5:3],
    // parity_error [6], read_data [38:7], zero [39]
    output logic [39:0]           o_m_tdata,
    // done_res
    output logic                  o_m_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_swd_cfg    w_cfg;
    t_swd_result w_result;
    t_swd_result r_out;
    logic        r_out_valid;
    logic        w_accept;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    swd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    swd_bit_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_accept       (w_accept),
        .i_command      (i_s_tuser),
        .i_req_nibble   (i_s_tdata[3:0]),
        .i_write_data   (i_s_tdata[35:4]),
        .i_swdio_in     (i_s_tdata[36]),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.done;
    assign o_m_tdata  = {1'b0, r_out.read_data, r_out.parity_error, r_out.ack_code,
                         r_out.busy, r_out.swdio_drive, r_out.swdio_out};

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD host transfer engine testbench
// Drives start and tick transactions into the engine and checks every result
// against a cycle-level model of the SWD bit sequence. Transfers are built
// from the model's own phase, so ACK and read data land on the right ticks.
// Reads, writes, WAIT, FAULT, invalid ACKs, parity errors, ignored starts and
// the register extremes are covered under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import swd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REQUEST,
        ST_TURN1,
        ST_ACK,
        ST_RDATA,
        ST_TURN2,
        ST_WDATA,
        ST_IDLE_CLK,
        ST_TAIL_IN,
        ST_TAIL_ZERO
    } t_bus_phase;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [39:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [39:0]           m_tdata;
    logic                  m_tlast;

    // Engine model state and its copy of the registers.
    t_swd_cfg   cfg;
    t_bus_phase phase;
    logic [7:0]  bit_cnt;
    logic [32:0] shift_word;
    logic [7:0]  req_packet;
    logic        is_read;
    logic [2:0]  ack_held;
    logic        parity_acc;

    t_swd_result pending_results[$];
    t_swd_result want;
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned transfers_started = 0;
    int unsigned transfers_done = 0;
    int unsigned errors = 0;
    int unsigned quiet_cycles = 0;

    swd_host_transfer_engine u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_bus_phase next_phase(t_bus_phase p);
        case (p)
            ST_REQUEST: return ST_TURN1;
            ST_TURN1:   return ST_ACK;
            ST_ACK:     return (ack_held == ACK_OK && is_read) ? ST_RDATA : ST_TURN2;
            ST_RDATA:   return ST_TURN2;
            ST_TURN2: begin
                if (ack_held == ACK_OK)
                    return is_read ? ST_IDLE_CLK : ST_WDATA;
                if (ack_held == ACK_WAIT || ack_held == ACK_FAULT) begin
                    if (!cfg.data_on_wait)
                        return ST_IDLE;
                    return is_read ? ST_TAIL_IN : ST_TAIL_ZERO;
                end
                return ST_TAIL_IN;
            end
            ST_WDATA:   return ST_IDLE_CLK;
            default:    return ST_IDLE;
        endcase
    endfunction

    function automatic logic [7:0] phase_clocks(t_bus_phase p);
        case (p)
            ST_REQUEST:              return 8'd8;
            ST_TURN1, ST_TURN2:      return {5'd0, cfg.turnaround};
            ST_ACK:                  return 8'd3;
            ST_RDATA, ST_WDATA,
            ST_TAIL_IN, ST_TAIL_ZERO: return 8'd33;
            ST_IDLE_CLK:             return cfg.idle_clocks;
            default:                 return 8'd0;
        endcase
    endfunction

    // Applies one input transaction to the model and returns the bus result.
    function automatic t_swd_result next_bus_result(logic cmd, logic [3:0] req,
                                                    logic [31:0] wdata, logic sin);
        t_swd_result r;
        t_bus_phase  p;
        logic [7:0]  n;
        r = '0;
        if (cmd == CMD_START) begin
            if (phase == ST_IDLE) begin
                is_read    = req[1];
                req_packet = REQ_FRAME | {3'd0, req, 1'b0} | {2'd0, ^req, 5'd0};
                shift_word = is_read ? 33'd0 : {^wdata, wdata};
                ack_held   = 3'd0;
                parity_acc = 1'b0;
                phase      = ST_REQUEST;
                bit_cnt    = 8'd8;
            end
        end else if (phase == ST_IDLE) begin
            r.swdio_out   = 1'b1;
            r.swdio_drive = 1'b1;
        end else begin
            case (phase)
                ST_REQUEST: begin
                    r.swdio_drive = 1'b1;
                    r.swdio_out   = req_packet[0];
                    req_packet    = req_packet >> 1;
                end
                ST_ACK: begin
                    if (bit_cnt >= 1 && bit_cnt <= 3)
                        ack_held[3 - bit_cnt] = ack_held[3 - bit_cnt] | sin;
                end
                ST_RDATA: begin
                    if (bit_cnt >= 1 && bit_cnt <= 33)
                        shift_word[33 - bit_cnt] = shift_word[33 - bit_cnt] | sin;
                    parity_acc = parity_acc ^ sin;
                end
                ST_WDATA: begin
                    r.swdio_drive = 1'b1;
                    r.swdio_out   = shift_word[0];
                    shift_word    = shift_word >> 1;
                end
                ST_IDLE_CLK, ST_TAIL_ZERO: begin
                    r.swdio_drive = 1'b1;
                end
                default: begin
                end
            endcase
            if (bit_cnt > 0)
                bit_cnt = bit_cnt - 8'd1;
            if (bit_cnt == 0) begin
                // Phases of zero length are skipped on the way to the next one.
                p = next_phase(phase);
                n = phase_clocks(p);
                while (p != ST_IDLE && n == 0) begin
                    p = next_phase(p);
                    n = phase_clocks(p);
                end
                phase   = p;
                bit_cnt = n;
                if (phase == ST_IDLE) begin
                    r.done = 1'b1;
                    if (ack_held == ACK_OK && is_read) begin
                        r.parity_error = parity_acc;
                        r.read_data    = shift_word[31:0];
                    end
                end
            end
        end
        r.busy     = (phase != ST_IDLE);
        r.ack_code = ack_held;
        return r;
    endfunction

    task automatic send_item(logic cmd, logic [3:0] req, logic [31:0] wdata, logic sin);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, sin, wdata, req};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(next_bus_result(cmd, req, wdata, sin));
        items_sent++;
    endtask

    task automatic send_idle_tick();
        send_item(CMD_TICK, 4'($urandom_range(15)), $urandom, 1'($urandom_range(1)));
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_results();
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TURNAROUND:   cfg.turnaround   = val[2:0];
            CFG_DATA_ON_WAIT: cfg.data_on_wait = val[0];
            CFG_IDLE_CLOCKS:  cfg.idle_clocks  = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_config(logic [2:0] trn, logic on_wait, logic [7:0] idle_clks);
        write_reg(CFG_TURNAROUND, {5'd0, trn});
        write_reg(CFG_DATA_ON_WAIT, {7'd0, on_wait});
        write_reg(CFG_IDLE_CLOCKS, idle_clks);
    endtask

    // Runs one whole transfer. The target side answers with the given ACK and,
    // on an OK read, with the given word; extra_start_at places an ignored start
    // before that tick of the transfer (negative for none).
    task automatic run_transfer(logic [3:0] req, logic [31:0] wdata, logic [2:0] ack,
                                logic [31:0] word, logic bad_parity, int extra_start_at);
        logic sin;
        int   tick_no;
        tick_no = 0;
        transfers_started++;
        send_item(CMD_START, req, wdata, 1'($urandom_range(1)));
        while (phase != ST_IDLE) begin
            if (tick_no == extra_start_at)
                send_item(CMD_START, 4'($urandom_range(15)), $urandom,
                          1'($urandom_range(1)));
            if (sender_idle_pct != 0 && $urandom_range(199) == 0)
                wait_results();
            sin = 1'($urandom_range(1));
            if (phase == ST_ACK)
                sin = ack[3 - bit_cnt];
            else if (phase == ST_RDATA)
                sin = (bit_cnt == 1) ? (^word ^ bad_parity) : word[33 - bit_cnt];
            send_item(CMD_TICK, 4'($urandom_range(15)), $urandom, sin);
            tick_no++;
        end
    endtask

    task automatic test_directed_transfers();
        sender_idle_pct = 0;
        stall_pct = 0;
        send_item(CMD_TICK, 4'h0, 32'h0000_0000, 1'b0);
        send_item(CMD_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1);
        run_transfer(4'b0010, 32'h0000_0000, ACK_OK, 32'hFFFF_FFFF, 1'b0, -1);
        run_transfer(4'b1101, 32'hFFFF_FFFF, ACK_OK, 32'h0000_0000, 1'b0, 5);
        run_transfer(4'b0110, $urandom, ACK_OK, 32'hA5A5_0F0F, 1'b1, 40);
        run_transfer(4'b1010, $urandom, ACK_WAIT, $urandom, 1'b0, -1);
        run_transfer(4'b0101, $urandom, ACK_FAULT, $urandom, 1'b0, -1);
        run_transfer(4'b0011, $urandom, 3'd0, $urandom, 1'b0, -1);
        wait_results();
        send_idle_tick();
    endtask

    task automatic test_register_extremes();
        // No turnaround and no idle tail, so several phases are skipped at once;
        // data phase after WAIT/FAULT.
        set_config(3'd0, 1'b1, 8'd0);
        run_transfer(4'b0010, $urandom, ACK_OK, $urandom, 1'b0, -1);
        run_transfer(4'b0001, $urandom, ACK_OK, $urandom, 1'b0, -1);
        run_transfer(4'b0110, $urandom, ACK_WAIT, $urandom, 1'b0, -1);
        run_transfer(4'b1001, $urandom, ACK_FAULT, $urandom, 1'b0, -1);
        // Longest turnaround and longest idle tail.
        set_config(3'd7, 1'b1, 8'd255);
        run_transfer(4'b1110, $urandom, ACK_OK, $urandom, 1'b0, -1);
        set_config(3'd1, 1'b0, 8'd0);
    endtask

    task automatic test_random_traffic(int unsigned send_idle, int unsigned recv_stall,
                                       int unsigned n_items);
        int unsigned first;
        int unsigned pick;
        logic [2:0]  trn;
        logic [7:0]  idle_clks;
        logic [2:0]  ack;
        sender_idle_pct = send_idle;
        stall_pct = recv_stall;
        first = items_sent;
        while (items_sent - first < n_items) begin
            if ($urandom_range(3) == 0) begin
                pick = $urandom_range(9);
                trn = (pick == 0) ? 3'd0 : (pick == 1) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(1, 4));
                idle_clks = ($urandom_range(7) == 0) ? 8'($urandom_range(40))
                                                     : 8'($urandom_range(7));
                set_config(trn, 1'($urandom_range(1)), idle_clks);
            end
            pick = $urandom_range(9);
            ack = (pick < 6) ? ACK_OK : (pick == 6) ? ACK_WAIT : (pick == 7) ? ACK_FAULT
                                                               : 3'($urandom_range(7));
            run_transfer(4'($urandom_range(15)), $urandom, ack, $urandom,
                         $urandom_range(9) == 0,
                         ($urandom_range(3) == 0) ? int'($urandom_range(60)) : -1);
            repeat ($urandom_range(2)) send_idle_tick();
        end
    endtask

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expected,
                     actual);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction: expected none, actual %h/%b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("swdio_out", 32'(want.swdio_out), 32'(m_tdata[0]));
                check_field("swdio_drive", 32'(want.swdio_drive), 32'(m_tdata[1]));
                check_field("busy", 32'(want.busy), 32'(m_tdata[2]));
                check_field("ack_code", 32'(want.ack_code), 32'(m_tdata[5:3]));
                check_field("parity_error", 32'(want.parity_error), 32'(m_tdata[6]));
                check_field("read_data", want.read_data, m_tdata[38:7]);
                check_field("done", 32'(want.done), 32'(m_tlast));
                results_seen++;
                if (m_tlast)
                    transfers_done++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding", $time,
                         pending_results.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        cfg        = '{turnaround: 3'd1, data_on_wait: 1'b0, idle_clocks: 8'd0};
        phase      = ST_IDLE;
        bit_cnt    = 8'd0;
        shift_word = 33'd0;
        req_packet = 8'd0;
        is_read    = 1'b0;
        ack_held   = 3'd0;
        parity_acc = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_transfers();
        test_register_extremes();
        test_random_traffic(0, 0, 35);
        test_random_traffic(74, 0, 35);
        test_random_traffic(0, 74, 35);
        test_random_traffic(16, 16, 35);

        wait_results();
        repeat (5) @(posedge clk);
        $display("Ran %0d input transactions, %0d results, %0d of %0d transfers completed.",
                 items_sent, results_seen, transfers_done, transfers_started);
        $display("Covered OK/WAIT/FAULT/invalid ACKs, parity errors, ignored starts, %s",
                 "register extremes and four idle patterns.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches found", errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
src/swd_pkg.sv
src/swd_cfg_regs.sv
src/swd_bit_engine.sv
src/swd_host_transfer_engine.sv
test/tb_top.sv
